>>> rtl/udpfb_pkg.sv
// Shared types and constants of the UDP/IPv4/Ethernet frame builder.
// Holds the configuration struct, the header position map and the frame state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package udpfb_pkg;

  localparam int LEN_W     = 11;
  localparam int HDR_IDX_W = 6;
  localparam int ACC_W     = 19;
  localparam int APB_AW    = 6;
  localparam int APB_DW    = 64;

  typedef logic [LEN_W-1:0]     len_t;
  typedef logic [HDR_IDX_W-1:0] hdr_idx_t;

  localparam len_t MAX_PAYLOAD = 11'd1472;

  // Option bits of the frame_options register.
  localparam int OPT_BCAST = 0;
  localparam int OPT_VLAN  = 1;
  localparam int OPT_HSR   = 2;

  // Byte positions in the full header layout; optional tags are skipped when off.
  localparam hdr_idx_t IDX_SMAC_LAST = 6'd11;
  localparam hdr_idx_t IDX_VLAN      = 6'd12;
  localparam hdr_idx_t IDX_VLAN_LAST = 6'd15;
  localparam hdr_idx_t IDX_HSR       = 6'd16;
  localparam hdr_idx_t IDX_HSR_LAST  = 6'd21;
  localparam hdr_idx_t IDX_TYPE      = 6'd22;
  localparam hdr_idx_t IDX_LAST      = 6'd51;

  typedef enum logic [1:0] {
    FS_START,
    FS_HEADER,
    FS_BODY
  } frame_state_t;

  typedef struct packed {
    logic [47:0] dest_mac;
    logic [47:0] source_mac;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [2:0]  frame_options;
  } udpfb_cfg_t;

  typedef struct packed {
    logic     step;
    hdr_idx_t idx;
    len_t     len;
  } hdr_ctl_t;

  function automatic hdr_idx_t next_hdr_idx(hdr_idx_t idx, logic vlan, logic hsr);
    hdr_idx_t nxt;
    nxt = idx + hdr_idx_t'(1);
    if (idx == IDX_SMAC_LAST) begin
      nxt = vlan ? IDX_VLAN : (hsr ? IDX_HSR : IDX_TYPE);
    end else if (idx == IDX_VLAN_LAST) begin
      nxt = hsr ? IDX_HSR : IDX_TYPE;
    end
    return nxt;
  endfunction

endpackage

`default_nettype wire

>>> rtl/udpfb_cfg.sv
// APB register file of the frame builder: addresses, ports and frame options.
// Depends on udpfb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module udpfb_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [udpfb_pkg::APB_AW-1:0] paddr,
  input  wire logic [udpfb_pkg::APB_DW-1:0] pwdata,
  output logic      [udpfb_pkg::APB_DW-1:0] prdata,
  output logic                              pready,
  output udpfb_pkg::udpfb_cfg_t             cfg
);
  import udpfb_pkg::*;

  localparam logic [2:0] REG_DEST_MAC      = 3'd0;
  localparam logic [2:0] REG_SOURCE_MAC    = 3'd1;
  localparam logic [2:0] REG_SOURCE_IP     = 3'd2;
  localparam logic [2:0] REG_DEST_IP       = 3'd3;
  localparam logic [2:0] REG_SOURCE_PORT   = 3'd4;
  localparam logic [2:0] REG_DEST_PORT     = 3'd5;
  localparam logic [2:0] REG_FRAME_OPTIONS = 3'd6;

  udpfb_cfg_t cfg_r, cfg_nxt;
  logic       wr_en;
  logic [2:0] reg_sel;

  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[APB_AW-1:3];
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_sel)
        REG_DEST_MAC:      cfg_nxt.dest_mac      = pwdata[47:0];
        REG_SOURCE_MAC:    cfg_nxt.source_mac    = pwdata[47:0];
        REG_SOURCE_IP:     cfg_nxt.source_ip     = pwdata[31:0];
        REG_DEST_IP:       cfg_nxt.dest_ip       = pwdata[31:0];
        REG_SOURCE_PORT:   cfg_nxt.source_port   = pwdata[15:0];
        REG_DEST_PORT:     cfg_nxt.dest_port     = pwdata[15:0];
        REG_FRAME_OPTIONS: cfg_nxt.frame_options = pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_DEST_MAC:      prdata = {16'd0, cfg_r.dest_mac};
      REG_SOURCE_MAC:    prdata = {16'd0, cfg_r.source_mac};
      REG_SOURCE_IP:     prdata = {32'd0, cfg_r.source_ip};
      REG_DEST_IP:       prdata = {32'd0, cfg_r.dest_ip};
      REG_SOURCE_PORT:   prdata = {48'd0, cfg_r.source_port};
      REG_DEST_PORT:     prdata = {48'd0, cfg_r.dest_port};
      REG_FRAME_OPTIONS: prdata = {61'd0, cfg_r.frame_options};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/udpfb_hdr.sv
// Header byte generator: selects the header byte at a given position and
// accumulates the IPv4 checksum and the HSR sequence. Depends on udpfb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module udpfb_hdr (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire udpfb_pkg::udpfb_cfg_t cfg,
  input  wire udpfb_pkg::hdr_ctl_t   hctl,
  output logic [7:0]                 hdr_byte
);
  import udpfb_pkg::*;

  // Constant words of the IPv4 header: version/IHL, flags DF, TTL and protocol.
  localparam logic [ACC_W-1:0] CSUM_BASE = 19'h04500 + 19'h04000 + 19'h00111;

  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [15:0]      seq_r, seq_nxt;
  logic [15:0]      ip_len, udp_len, hsr_len, csum;

  assign ip_len  = 16'(hctl.len) + 16'd28;
  assign udp_len = 16'(hctl.len) + 16'd8;
  assign hsr_len = ip_len + 16'd6;
  assign csum    = ~acc_r[15:0];

  // The checksum is summed and folded during the MAC address bytes, long before
  // its own bytes go out.
  always_comb begin
    acc_nxt = acc_r;
    if (hctl.step) begin
      case (hctl.idx)
        6'd0: acc_nxt = CSUM_BASE + ACC_W'(ip_len) + ACC_W'(cfg.source_ip[31:16]);
        6'd1: acc_nxt = acc_r + ACC_W'(cfg.source_ip[15:0]);
        6'd2: acc_nxt = acc_r + ACC_W'(cfg.dest_ip[31:16]);
        6'd3: acc_nxt = acc_r + ACC_W'(cfg.dest_ip[15:0]);
        6'd4, 6'd5: acc_nxt = ACC_W'(acc_r[15:0]) + ACC_W'(acc_r[ACC_W-1:16]);
        default: ;
      endcase
    end
  end

  assign seq_nxt = (hctl.step && hctl.idx == IDX_HSR_LAST) ? seq_r + 16'd1 : seq_r;

  always_comb begin
    case (hctl.idx)
      6'd0:  hdr_byte = cfg.dest_mac[47:40] | {7'd0, cfg.frame_options[OPT_BCAST]};
      6'd1:  hdr_byte = cfg.dest_mac[39:32];
      6'd2:  hdr_byte = cfg.dest_mac[31:24];
      6'd3:  hdr_byte = cfg.dest_mac[23:16];
      6'd4:  hdr_byte = cfg.dest_mac[15:8];
      6'd5:  hdr_byte = cfg.dest_mac[7:0];
      6'd6:  hdr_byte = cfg.source_mac[47:40];
      6'd7:  hdr_byte = cfg.source_mac[39:32];
      6'd8:  hdr_byte = cfg.source_mac[31:24];
      6'd9:  hdr_byte = cfg.source_mac[23:16];
      6'd10: hdr_byte = cfg.source_mac[15:8];
      6'd11: hdr_byte = cfg.source_mac[7:0];
      6'd12: hdr_byte = 8'h81;
      6'd13: hdr_byte = 8'h00;
      6'd14: hdr_byte = 8'h00;
      6'd15: hdr_byte = 8'h00;
      6'd16: hdr_byte = 8'h89;
      6'd17: hdr_byte = 8'h2F;
      6'd18: hdr_byte = hsr_len[15:8];
      6'd19: hdr_byte = hsr_len[7:0];
      6'd20: hdr_byte = seq_r[15:8];
      6'd21: hdr_byte = seq_r[7:0];
      6'd22: hdr_byte = 8'h08;
      6'd23: hdr_byte = 8'h00;
      6'd24: hdr_byte = 8'h45;
      6'd25: hdr_byte = 8'h00;
      6'd26: hdr_byte = ip_len[15:8];
      6'd27: hdr_byte = ip_len[7:0];
      6'd28: hdr_byte = 8'h00;
      6'd29: hdr_byte = 8'h00;
      6'd30: hdr_byte = 8'h40;
      6'd31: hdr_byte = 8'h00;
      6'd32: hdr_byte = 8'h01;
      6'd33: hdr_byte = 8'h11;
      6'd34: hdr_byte = csum[15:8];
      6'd35: hdr_byte = csum[7:0];
      6'd36: hdr_byte = cfg.source_ip[31:24];
      6'd37: hdr_byte = cfg.source_ip[23:16];
      6'd38: hdr_byte = cfg.source_ip[15:8];
      6'd39: hdr_byte = cfg.source_ip[7:0];
      6'd40: hdr_byte = cfg.dest_ip[31:24];
      6'd41: hdr_byte = cfg.dest_ip[23:16];
      6'd42: hdr_byte = cfg.dest_ip[15:8];
      6'd43: hdr_byte = cfg.dest_ip[7:0];
      6'd44: hdr_byte = cfg.source_port[15:8];
      6'd45: hdr_byte = cfg.source_port[7:0];
      6'd46: hdr_byte = cfg.dest_port[15:8];
      6'd47: hdr_byte = cfg.dest_port[7:0];
      6'd48: hdr_byte = udp_len[15:8];
      6'd49: hdr_byte = udp_len[7:0];
      default: hdr_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= 16'd1;
    end else begin
      seq_r <= seq_nxt;
    end
  end

  a_vlan_only_when_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    (hctl.step && hctl.idx >= IDX_VLAN && hctl.idx <= IDX_VLAN_LAST)
      |-> cfg.frame_options[OPT_VLAN])
    else $error("VLAN tag byte emitted with VLAN option off");

  a_hsr_only_when_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    (hctl.step && hctl.idx >= IDX_HSR && hctl.idx <= IDX_HSR_LAST)
      |-> cfg.frame_options[OPT_HSR])
    else $error("HSR tag byte emitted with HSR option off");

  a_seq_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (hctl.step && hctl.idx == IDX_HSR_LAST) |=> (seq_r == $past(seq_r) + 16'd1))
    else $error("HSR sequence did not advance after its tag");

endmodule

`default_nettype wire

>>> rtl/udpfb_ctrl.sv
// Frame sequencer: input register, header position counter and payload count.
// Decides which byte goes out each cycle. Depends on udpfb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module udpfb_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [7:0]             in_payload_byte,
  input  wire udpfb_pkg::len_t        in_payload_length,
  input  wire logic [2:0]             frame_options,
  input  wire logic                   room,
  input  wire logic [7:0]             hdr_byte,
  output udpfb_pkg::hdr_ctl_t         hctl,
  output logic                        load,
  output logic [7:0]                  emit_byte,
  output logic                        emit_end
);
  import udpfb_pkg::*;

  logic         iv_r;
  logic [7:0]   ib_r;
  len_t         il_r;
  frame_state_t state_r, state_nxt;
  hdr_idx_t     idx_r, idx_nxt;
  len_t         pcount_r, pcount_nxt;

  len_t         len_c;
  hdr_idx_t     cur_idx;
  logic         go, hdr_last, consume;
  logic [LEN_W:0] pc_inc;

  assign len_c    = (il_r > MAX_PAYLOAD) ? MAX_PAYLOAD : il_r;
  assign cur_idx  = (state_r == FS_START) ? '0 : idx_r;
  assign go       = iv_r & room;
  assign hdr_last = (cur_idx == IDX_LAST);
  assign pc_inc   = {1'b0, pcount_r} + {{LEN_W{1'b0}}, 1'b1};

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    pcount_nxt = pcount_r;
    emit_byte  = hdr_byte;
    emit_end   = 1'b0;
    consume    = 1'b0;
    case (state_r)
      FS_START, FS_HEADER: begin
        // A zero-length frame ends on its last header byte.
        if (hdr_last && len_c == '0) begin
          emit_end = 1'b1;
          consume  = 1'b1;
        end
        if (go) begin
          if (hdr_last) begin
            state_nxt = (len_c == '0) ? FS_START : FS_BODY;
            idx_nxt   = '0;
          end else begin
            state_nxt = FS_HEADER;
            idx_nxt   = next_hdr_idx(cur_idx, frame_options[OPT_VLAN],
                                     frame_options[OPT_HSR]);
          end
        end
      end
      FS_BODY: begin
        emit_byte = ib_r;
        consume   = 1'b1;
        emit_end  = (pc_inc >= {1'b0, len_c});
        if (go) begin
          if (emit_end) begin
            pcount_nxt = '0;
            state_nxt  = FS_START;
          end else begin
            pcount_nxt = pc_inc[LEN_W-1:0];
          end
        end
      end
      default: begin
        state_nxt = FS_START;
      end
    endcase
  end

  assign in_ready  = ~iv_r | (room & consume);
  assign load      = go;
  assign hctl.step = go & (state_r != FS_BODY);
  assign hctl.idx  = cur_idx;
  assign hctl.len  = len_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r     <= 1'b0;
      state_r  <= FS_START;
      idx_r    <= '0;
      pcount_r <= '0;
    end else begin
      if (in_ready) begin
        iv_r <= in_valid;
      end
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      pcount_r <= pcount_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ib_r <= in_payload_byte;
      il_r <= in_payload_length;
    end
  end

  a_header_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FS_HEADER) |-> iv_r)
    else $error("header in progress without a held item");

  a_header_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FS_HEADER) |-> (idx_r != '0 && idx_r <= IDX_LAST))
    else $error("header position out of range");

  a_count_only_in_body: assert property (@(posedge clk) disable iff (!rst_n)
    (pcount_r != '0) |-> (state_r == FS_BODY))
    else $error("payload count nonzero outside the payload phase");

endmodule

`default_nettype wire

>>> rtl/udpfb_out.sv
// Output register of the frame builder: holds one frame byte until taken.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module udpfb_out (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       load,
  input  wire logic [7:0] byte_in,
  input  wire logic       end_in,
  input  wire logic       out_ready,
  output logic            out_valid,
  output logic [7:0]      out_frame_byte,
  output logic            out_frame_end,
  output logic            room
);

  logic       valid_r;
  logic [7:0] byte_r;
  logic       end_r;

  // The register can take a new byte when empty or when its byte leaves now.
  assign room           = ~valid_r | out_ready;
  assign out_valid      = valid_r;
  assign out_frame_byte = byte_r;
  assign out_frame_end  = end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (room) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (room && load) begin
      byte_r <= byte_in;
      end_r  <= end_in;
    end
  end

endmodule

`default_nettype wire

>>> rtl/udp_ip_eth_frame_builder_unit.sv
// Top level of the UDP/IPv4/Ethernet frame builder.
// Depends on udpfb_pkg, udpfb_cfg, udpfb_hdr, udpfb_ctrl and udpfb_out.
//
// Each input item is one UDP payload byte tagged with the frame's payload length
// (clamped to 1472). The first item of a frame produces the full header, one byte
// per cycle while the output register has room: 42 bytes, plus 4 with the VLAN
// tag and 6 with the HSR tag, then that item's payload byte, and in_ready stays
// low until its last byte is loaded. Later items of the frame carry the payload,
// which streams at one byte per cycle while the output register has room; for a
// zero-length frame the last header byte carries frame_end. The header position
// counter steps through the header bytes. A single output register holds each
// frame byte until it is taken, and out_ready reaches in_ready combinationally
// through it. Registers sit at byte address 8*i on the 64-bit APB port.
// They are read while a frame's header goes out, so the user must see that they
// are written only between frames; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module udp_ip_eth_frame_builder_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [udpfb_pkg::APB_AW-1:0] paddr,
  input  wire logic [udpfb_pkg::APB_DW-1:0] pwdata,
  output logic      [udpfb_pkg::APB_DW-1:0] prdata,
  output logic                              pready,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [7:0]                   in_payload_byte,
  input  wire logic [udpfb_pkg::LEN_W-1:0]  in_payload_length,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [7:0]                        out_frame_byte,
  output logic                              out_frame_end
);
  import udpfb_pkg::*;

  udpfb_cfg_t cfg;
  hdr_ctl_t   hctl;
  logic [7:0] hdr_byte;
  logic [7:0] emit_byte;
  logic       emit_end;
  logic       load;
  logic       room;

  udpfb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  udpfb_hdr u_hdr (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .hctl     (hctl),
    .hdr_byte (hdr_byte)
  );

  udpfb_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_payload_byte   (in_payload_byte),
    .in_payload_length (in_payload_length),
    .frame_options     (cfg.frame_options),
    .room              (room),
    .hdr_byte          (hdr_byte),
    .hctl              (hctl),
    .load              (load),
    .emit_byte         (emit_byte),
    .emit_end          (emit_end)
  );

  udpfb_out u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (load),
    .byte_in        (emit_byte),
    .end_in         (emit_end),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_frame_byte (out_frame_byte),
    .out_frame_end  (out_frame_end),
    .room           (room)
  );

endmodule

`default_nettype wire
